// ===== design/assert_macros.svh =====
// assertion macros used by the bssid table checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define BDT_ASSERT_IMP(lbl, clk, dis, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("bdt assertion failed");

// next-cycle implication
`define BDT_ASSERT_NXT(lbl, clk, dis, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("bdt assertion failed");

`endif

// ===== design/bdt_pkg.sv =====
// types and constants of the bssid de-duplicating table
package bdt_pkg;

  localparam int TABLE_DEPTH_DEF = 2048;
  localparam int CNT_W           = 12;
  localparam int IDX_OUT_W       = 11;
  localparam int ADDR_W          = 48;
  localparam int SIG_W           = 20;
  localparam int LAT_W           = 28;
  localparam int LON_W           = 29;
  localparam int POS_W           = LAT_W + LON_W;
  localparam int ALT_W           = 18;
  localparam int TIME_W          = 32;
  localparam int IN_TDATA_W      = 176;
  localparam int OUT_TDATA_W     = 80;

  localparam logic [CNT_W-1:0] ENTRY_LIMIT_RESET = 12'd2000;

  localparam logic [3:0] AUTH_OPEN = 4'd0;
  localparam logic [3:0] AUTH_WEP  = 4'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_HIT_UPD,
    ST_MISS
  } bdt_state_t;

  // first member sits in the top bits, so found lands in bit 0
  typedef struct packed {
    logic [4:0]           pad;
    logic [CNT_W-1:0]     new_in_scan;
    logic [CNT_W-1:0]     wpa_count;
    logic [CNT_W-1:0]     wep_count;
    logic [CNT_W-1:0]     open_count;
    logic [CNT_W-1:0]     total_count;
    logic                 table_flushed;
    logic                 position_updated;
    logic                 inserted;
    logic [IDX_OUT_W-1:0] entry_index;
    logic                 found;
  } bdt_result_t;

endpackage

// ===== design/bssid_dedup_table.sv =====
// bssid de-duplicating access-point table with linear memory search
//
//  port group  dir  fields (lowest bit first)
//  in_         in   tdata: bssid, rssi, channel, auth_mode, latitude, longitude,
//                   altitude, seen_time; tuser: gps_valid; tlast: last_of_scan
//  out_        out  tdata: found, entry_index, inserted, position_updated,
//                   table_flushed, total/open/wep/wpa counts, new_in_scan
//  cfg_        in   wr_data: entry limit
//
//  a miss: accept, one address read per stored entry, the registered compare,
//  then write-back; an empty table goes from accept straight to write-back
//  a hit in slot n stops the search, its record read overlaps the search
//  reset is synchronous and immediate, the memories need no clearing pass
//  a held result stalls write-back; no new record is taken until it is done
module bssid_dedup_table #(
  parameter int TABLE_DEPTH = bdt_pkg::TABLE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [bdt_pkg::CNT_W-1:0]          cfg_wr_data,  // entry limit
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // bssid, rssi, channel, auth_mode, latitude, longitude, altitude, seen_time
  input  logic [bdt_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                               in_tuser,     // gps_valid
  input  logic                               in_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // found, entry_index, inserted, position_updated, table_flushed, total_count,
  // open_count, wep_count, wpa_count, new_in_scan
  output logic [bdt_pkg::OUT_TDATA_W-1:0]    out_tdata
);
  import bdt_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int PTR_W = (IDX_W + 1 > CNT_W) ? IDX_W + 1 : CNT_W;
  localparam int REC_W = TIME_W + ALT_W + POS_W + SIG_W;

  bdt_state_t state_r, state_nxt;

  logic [CNT_W-1:0]  cfg_max_r;

  logic [ADDR_W-1:0] bssid_r;
  logic [7:0]        rssi_r;
  logic [7:0]        chan_r;
  logic [3:0]        auth_r;
  logic              gps_r;
  logic [LAT_W-1:0]  lat_r;
  logic [LON_W-1:0]  lon_r;
  logic [ALT_W-1:0]  alt_r;
  logic [TIME_W-1:0] time_r;
  logic              last_r;

  logic [CNT_W-1:0]  fill_r, open_r, wep_r, wpa_r, scan_r;

  logic [PTR_W-1:0]  ptr_r;
  logic [PTR_W-1:0]  cmp_idx_r;
  logic              cmp_vld_r;
  logic [IDX_W-1:0]  hit_idx_r;

  // record word from the top: seen_time, altitude, position, signal
  logic [ADDR_W-1:0] addr_mem [TABLE_DEPTH];
  logic [REC_W-1:0]  rec_mem  [TABLE_DEPTH];

  logic [ADDR_W-1:0] addr_q;
  logic [REC_W-1:0]  rec_q;
  logic [SIG_W-1:0]  sig_q;
  logic [POS_W-1:0]  pos_q;

  bdt_result_t       out_r;
  logic              out_vld_r;

  logic              in_acc, out_free;
  logic              hit, last_cmp;
  logic              addr_rd_en, rec_rd_en, done, wr_hit, wr_miss;
  logic [PTR_W-1:0]  fill_ext;
  logic              full;
  logic [IDX_W-1:0]  ins_idx;
  logic [IDX_W-1:0]  wr_idx;
  logic              upd;
  logic [CNT_W-1:0]  fill_new, open_new, wep_new, wpa_new, scan_new;
  logic [SIG_W-1:0]  sig_wd;
  logic [POS_W-1:0]  pos_wd;
  logic [ALT_W-1:0]  alt_wd;
  logic [TIME_W-1:0] time_wd;
  logic [REC_W-1:0]  rec_wd;
  bdt_result_t       res;

  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_vld_r || out_tready;
  assign fill_ext = PTR_W'(fill_r);
  assign hit      = cmp_vld_r && (cmp_idx_r < fill_ext) && (addr_q == bssid_r);
  assign last_cmp = cmp_vld_r && (PTR_W'(cmp_idx_r + 1'b1) >= fill_ext);
  assign sig_q    = rec_q[SIG_W-1:0];
  assign pos_q    = rec_q[SIG_W +: POS_W];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (fill_r == '0) ? ST_MISS : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (hit) begin
          state_nxt = ST_HIT_UPD;
        end else if (last_cmp) begin
          state_nxt = ST_MISS;
        end
      end
      ST_HIT_UPD: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_MISS: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  // state outputs
  always_comb begin
    in_tready  = 1'b0;
    addr_rd_en = 1'b0;
    rec_rd_en  = 1'b0;
    done       = 1'b0;
    wr_hit     = 1'b0;
    wr_miss    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
      end
      ST_SEARCH: begin
        addr_rd_en = 1'b1;
        rec_rd_en  = hit;
      end
      ST_HIT_UPD: begin
        done   = out_free;
        wr_hit = out_free && upd;
      end
      ST_MISS: begin
        done    = out_free;
        wr_miss = out_free;
      end
    endcase
  end

  // insert and update arithmetic and the result word
  always_comb begin
    full     = (fill_ext >= PTR_W'(cfg_max_r)) || (int'(fill_r) >= TABLE_DEPTH);
    ins_idx  = full ? '0 : fill_ext[IDX_W-1:0];
    fill_new = full ? CNT_W'(1) : fill_r + 1'b1;
    open_new = full ? '0 : open_r;
    wep_new  = full ? '0 : wep_r;
    wpa_new  = full ? '0 : wpa_r;
    scan_new = (full ? '0 : scan_r) + 1'b1;
    priority if (auth_r == AUTH_OPEN) begin
      open_new = open_new + 1'b1;
    end else if (auth_r == AUTH_WEP) begin
      wep_new = wep_new + 1'b1;
    end else begin
      wpa_new = wpa_new + 1'b1;
    end

    upd = gps_r && ((pos_q[LAT_W-1:0] == '0) || ($signed(rssi_r) > $signed(sig_q[7:0])));

    wr_idx  = wr_miss ? ins_idx : hit_idx_r;
    sig_wd  = wr_miss ? {auth_r, chan_r, rssi_r} : {sig_q[SIG_W-1:8], rssi_r};
    pos_wd  = (wr_miss && !gps_r) ? '0 : {lon_r, lat_r};
    alt_wd  = (wr_miss && !gps_r) ? '0 : alt_r;
    time_wd = wr_miss ? time_r : rec_q[REC_W-1 -: TIME_W];
    rec_wd  = {time_wd, alt_wd, pos_wd, sig_wd};

    res                  = '0;
    res.total_count      = fill_r;
    res.open_count       = open_r;
    res.wep_count        = wep_r;
    res.wpa_count        = wpa_r;
    res.new_in_scan      = scan_r;
    if (state_r == ST_MISS) begin
      res.entry_index   = IDX_OUT_W'(ins_idx);
      res.inserted      = 1'b1;
      res.table_flushed = full;
      res.total_count   = fill_new;
      res.open_count    = open_new;
      res.wep_count     = wep_new;
      res.wpa_count     = wpa_new;
      res.new_in_scan   = scan_new;
    end else begin
      res.found            = 1'b1;
      res.entry_index      = IDX_OUT_W'(hit_idx_r);
      res.position_updated = upd;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cfg_max_r <= ENTRY_LIMIT_RESET;
      fill_r    <= '0;
      open_r    <= '0;
      wep_r     <= '0;
      wpa_r     <= '0;
      scan_r    <= '0;
      cmp_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cmp_vld_r <= (state_r == ST_SEARCH);
      if (cfg_wr_en) begin
        cfg_max_r <= cfg_wr_data;
      end
      if (wr_miss) begin
        fill_r <= fill_new;
        open_r <= open_new;
        wep_r  <= wep_new;
        wpa_r  <= wpa_new;
        scan_r <= last_r ? '0 : scan_new;
      end else if (done && last_r) begin
        scan_r <= '0;
      end
      if (done) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // record latch, search pointer and result register
  always_ff @(posedge clk) begin
    if (in_acc) begin
      bssid_r <= in_tdata[47:0];
      rssi_r  <= in_tdata[55:48];
      chan_r  <= in_tdata[63:56];
      auth_r  <= in_tdata[67:64];
      lat_r   <= in_tdata[95:68];
      lon_r   <= in_tdata[124:96];
      alt_r   <= in_tdata[142:125];
      time_r  <= in_tdata[174:143];
      gps_r   <= in_tuser;
      last_r  <= in_tlast;
      ptr_r   <= '0;
    end else if (state_r == ST_SEARCH) begin
      ptr_r <= ptr_r + 1'b1;
    end
    cmp_idx_r <= ptr_r;
    if (rec_rd_en) begin
      hit_idx_r <= cmp_idx_r[IDX_W-1:0];
    end
    if (done) begin
      out_r <= res;
    end
  end

  // address store
  always_ff @(posedge clk) begin
    if (addr_rd_en) begin
      addr_q <= addr_mem[ptr_r[IDX_W-1:0]];
    end
    if (wr_miss) begin
      addr_mem[ins_idx] <= bssid_r;
    end
  end

  // record store
  always_ff @(posedge clk) begin
    if (rec_rd_en) begin
      rec_q <= rec_mem[cmp_idx_r[IDX_W-1:0]];
    end
    if (wr_miss || wr_hit) begin
      rec_mem[wr_idx] <= rec_wd;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_r;

endmodule

// ===== design/bdt_checker.sv =====
// port-level checker for the bssid table and its bind
`include "assert_macros.svh"

module bdt_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [bdt_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import bdt_pkg::*;

  bdt_result_t res;

  assign res = out_tdata;

  `BDT_ASSERT_NXT(a_rst_quiet, clk, 1'b0, !rst_n, !out_tvalid)
  `BDT_ASSERT_NXT(a_out_hold, clk, !rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `BDT_ASSERT_IMP(a_hit_excl, clk, !rst_n, out_tvalid && res.found, !res.inserted && !res.table_flushed)
  `BDT_ASSERT_IMP(a_flush_restart, clk, !rst_n, out_tvalid && res.table_flushed, res.inserted && (res.entry_index == '0) && (res.total_count == 12'd1))
  `BDT_ASSERT_IMP(a_count_sum, clk, !rst_n, out_tvalid, res.total_count == res.open_count + res.wep_count + res.wpa_count)

endmodule

bind bssid_dedup_table bdt_checker u_bdt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
